FILE: hdl/mrp_pkg.sv
package mrp_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 28;

   // exact intermediate widths
   localparam int PROD_W = 2 * WORD_BITS;          // one 32x32 product
   localparam int SUM_W  = 2 * WORD_BITS + 2;      // |a|^2, |b|^2, a.b, b x a, 1-|a|^2
   localparam int HI_W   = SUM_W - WORD_BITS;      // upper slice of a split operand
   localparam int PP_W   = 2 * WORD_BITS + 4;      // partial products
   localparam int DEN_W  = 4 * WORD_BITS + 4;      // denominator, 4F fraction bits
   localparam int NUM_W  = 3 * WORD_BITS + 4;      // numerator, 3F fraction bits
   localparam int N_W    = 3 * WORD_BITS + 2 * FRAC_BITS + 6; // dividend
   localparam int REM_W  = DEN_W + 1;              // partial remainder

   localparam int FE_STAGES = 7;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = Q_PTR_W + 1;

   localparam logic signed [SUM_W-1:0] ONE_2F = SUM_W'(1) <<< (2 * FRAC_BITS);
   localparam logic signed [DEN_W-1:0] ONE_4F = DEN_W'(1) <<< (4 * FRAC_BITS);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_SAT      = 2'd1,
      ST_ZERO_DEN = 2'd2
   } status_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [2:0][N_W-1:0] n;     // |num| * 2^(2F+1) + |den|
      logic [DEN_W-1:0]    d;     // 2 * |den|
      logic [2:0]          neg;   // result sign per component
      logic                zero;  // zero denominator
   } fe_item_type;

endpackage

FILE: hdl/mrp_ifs.sv
interface mrp_req_if;
   logic valid;
   logic ready;
   logic signed [mrp_pkg::WORD_BITS-1:0] a_x;
   logic signed [mrp_pkg::WORD_BITS-1:0] a_y;
   logic signed [mrp_pkg::WORD_BITS-1:0] a_z;
   logic signed [mrp_pkg::WORD_BITS-1:0] b_x;
   logic signed [mrp_pkg::WORD_BITS-1:0] b_y;
   logic signed [mrp_pkg::WORD_BITS-1:0] b_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface mrp_rsp_if;
   logic valid;
   logic ready;
   logic signed [mrp_pkg::WORD_BITS-1:0] f_x;
   logic signed [mrp_pkg::WORD_BITS-1:0] f_y;
   logic signed [mrp_pkg::WORD_BITS-1:0] f_z;
   logic [1:0] status;

   modport source (output valid, f_x, f_y, f_z, status, input ready);
   modport sink   (input valid, f_x, f_y, f_z, status, output ready);
endinterface

FILE: hdl/mrp_front.sv
module mrp_front (
   input  logic                 clock,
   input  logic                 reset,
   mrp_req_if.sink              req_chan,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mrp_pkg::fe_item_type out_item
);
   import mrp_pkg::*;

   logic                     en;
   logic [FE_STAGES-1:0]     v_ff;
   logic signed [WORD_BITS-1:0] a_w [3];
   logic signed [WORD_BITS-1:0] b_w [3];

   // stage 1: products
   logic signed [WORD_BITS-1:0] s1_a_ff [3];
   logic signed [WORD_BITS-1:0] s1_b_ff [3];
   logic signed [PROD_W-1:0]    s1_aa_ff [3];
   logic signed [PROD_W-1:0]    s1_bb_ff [3];
   logic signed [PROD_W-1:0]    s1_ab_ff [3];
   logic signed [PROD_W-1:0]    s1_cp_ff [3];
   logic signed [PROD_W-1:0]    s1_cn_ff [3];
   // stage 2: sums
   logic signed [WORD_BITS-1:0] s2_a_ff [3];
   logic signed [WORD_BITS-1:0] s2_b_ff [3];
   logic signed [SUM_W-1:0]     s2_a2_ff, s2_b2_ff, s2_ab_ff, s2_ma_ff, s2_mb_ff;
   logic signed [SUM_W-1:0]     s2_c_ff [3];
   // stage 3: partial products
   logic signed [PP_W-1:0]      s3_ll_ff, s3_lh_ff, s3_hl_ff, s3_hh_ff;
   logic signed [PP_W-1:0]      s3_mah_ff [3];
   logic signed [PP_W-1:0]      s3_mal_ff [3];
   logic signed [PP_W-1:0]      s3_mbh_ff [3];
   logic signed [PP_W-1:0]      s3_mbl_ff [3];
   logic signed [SUM_W-1:0]     s3_ab_ff;
   logic signed [SUM_W-1:0]     s3_c_ff [3];
   // stage 4: wide products
   logic signed [DEN_W-1:0]     s4_a2b2_ff;
   logic signed [NUM_W-1:0]     s4_t_ff [3];
   logic signed [SUM_W-1:0]     s4_ab_ff;
   logic signed [SUM_W-1:0]     s4_c_ff [3];
   // stage 5: numerator and denominator
   logic signed [DEN_W-1:0]     s5_den_ff;
   logic signed [NUM_W-1:0]     s5_num_ff [3];
   // stage 6: magnitudes and signs
   logic [DEN_W-1:0]            s6_d_ff;
   logic [NUM_W-1:0]            s6_n_ff [3];
   logic [2:0]                  s6_neg_ff;
   logic                        s6_zero_ff;
   // stage 7: dividend and divisor
   fe_item_type                 s7_item_ff;

   assign a_w[0] = req_chan.a_x;
   assign a_w[1] = req_chan.a_y;
   assign a_w[2] = req_chan.a_z;
   assign b_w[0] = req_chan.b_x;
   assign b_w[1] = req_chan.b_y;
   assign b_w[2] = req_chan.b_z;

   assign en             = !v_ff[FE_STAGES-1] || out_ready;
   assign req_chan.ready = en;
   assign out_valid      = v_ff[FE_STAGES-1];
   assign out_item       = s7_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[FE_STAGES-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_a_ff[i]  <= a_w[i];
            s1_b_ff[i]  <= b_w[i];
            s1_aa_ff[i] <= a_w[i] * a_w[i];
            s1_bb_ff[i] <= b_w[i] * b_w[i];
            s1_ab_ff[i] <= a_w[i] * b_w[i];
            // b x a
            s1_cp_ff[i] <= b_w[(i + 1) % 3] * a_w[(i + 2) % 3];
            s1_cn_ff[i] <= b_w[(i + 2) % 3] * a_w[(i + 1) % 3];
         end

         for (int i = 0; i < 3; i++) begin
            s2_a_ff[i] <= s1_a_ff[i];
            s2_b_ff[i] <= s1_b_ff[i];
            s2_c_ff[i] <= SUM_W'(s1_cp_ff[i]) - SUM_W'(s1_cn_ff[i]);
         end
         s2_a2_ff <= SUM_W'(s1_aa_ff[0]) + SUM_W'(s1_aa_ff[1]) + SUM_W'(s1_aa_ff[2]);
         s2_b2_ff <= SUM_W'(s1_bb_ff[0]) + SUM_W'(s1_bb_ff[1]) + SUM_W'(s1_bb_ff[2]);
         s2_ab_ff <= SUM_W'(s1_ab_ff[0]) + SUM_W'(s1_ab_ff[1]) + SUM_W'(s1_ab_ff[2]);
         s2_ma_ff <= ONE_2F - SUM_W'(s1_aa_ff[0]) - SUM_W'(s1_aa_ff[1])
                     - SUM_W'(s1_aa_ff[2]);
         s2_mb_ff <= ONE_2F - SUM_W'(s1_bb_ff[0]) - SUM_W'(s1_bb_ff[1])
                     - SUM_W'(s1_bb_ff[2]);

         // operands split into a low unsigned and a high signed slice
         s3_ll_ff <= PP_W'($signed({1'b0, s2_a2_ff[WORD_BITS-1:0]})
                     * $signed({1'b0, s2_b2_ff[WORD_BITS-1:0]}));
         s3_lh_ff <= PP_W'($signed({1'b0, s2_a2_ff[WORD_BITS-1:0]})
                     * $signed(s2_b2_ff[SUM_W-1:WORD_BITS]));
         s3_hl_ff <= PP_W'($signed(s2_a2_ff[SUM_W-1:WORD_BITS])
                     * $signed({1'b0, s2_b2_ff[WORD_BITS-1:0]}));
         s3_hh_ff <= PP_W'($signed(s2_a2_ff[SUM_W-1:WORD_BITS])
                     * $signed(s2_b2_ff[SUM_W-1:WORD_BITS]));
         for (int i = 0; i < 3; i++) begin
            s3_mah_ff[i] <= PP_W'($signed(s2_ma_ff[SUM_W-1:WORD_BITS]) * s2_b_ff[i]);
            s3_mal_ff[i] <= PP_W'($signed({1'b0, s2_ma_ff[WORD_BITS-1:0]}) * s2_b_ff[i]);
            s3_mbh_ff[i] <= PP_W'($signed(s2_mb_ff[SUM_W-1:WORD_BITS]) * s2_a_ff[i]);
            s3_mbl_ff[i] <= PP_W'($signed({1'b0, s2_mb_ff[WORD_BITS-1:0]}) * s2_a_ff[i]);
            s3_c_ff[i]   <= s2_c_ff[i];
         end
         s3_ab_ff <= s2_ab_ff;

         s4_a2b2_ff <= (DEN_W'(s3_hh_ff) <<< (2 * WORD_BITS))
                       + ((DEN_W'(s3_lh_ff) + DEN_W'(s3_hl_ff)) <<< WORD_BITS)
                       + DEN_W'(s3_ll_ff);
         for (int i = 0; i < 3; i++) begin
            s4_t_ff[i] <= (NUM_W'(s3_mah_ff[i]) <<< WORD_BITS) + NUM_W'(s3_mal_ff[i])
                          + (NUM_W'(s3_mbh_ff[i]) <<< WORD_BITS) + NUM_W'(s3_mbl_ff[i]);
            s4_c_ff[i] <= s3_c_ff[i];
         end
         s4_ab_ff <= s3_ab_ff;

         s5_den_ff <= ONE_4F + s4_a2b2_ff - (DEN_W'(s4_ab_ff) <<< (2 * FRAC_BITS + 1));
         for (int i = 0; i < 3; i++) begin
            s5_num_ff[i] <= s4_t_ff[i] - (NUM_W'(s4_c_ff[i]) <<< (FRAC_BITS + 1));
         end

         s6_zero_ff <= (s5_den_ff == '0);
         s6_d_ff    <= s5_den_ff[DEN_W-1] ? $unsigned(-s5_den_ff) : $unsigned(s5_den_ff);
         for (int i = 0; i < 3; i++) begin
            s6_n_ff[i]   <= s5_num_ff[i][NUM_W-1] ? $unsigned(-s5_num_ff[i])
                                                  : $unsigned(s5_num_ff[i]);
            s6_neg_ff[i] <= s5_num_ff[i][NUM_W-1] ^ s5_den_ff[DEN_W-1];
         end

         for (int i = 0; i < 3; i++) begin
            s7_item_ff.n[i] <= (N_W'(s6_n_ff[i]) << (2 * FRAC_BITS + 1)) + N_W'(s6_d_ff);
         end
         s7_item_ff.d    <= s6_d_ff << 1;
         s7_item_ff.neg  <= s6_neg_ff;
         s7_item_ff.zero <= s6_zero_ff;
      end
   end

endmodule

FILE: hdl/mrp_queue.sv
module mrp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mrp_pkg::fe_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mrp_pkg::fe_item_type out_item
);
   import mrp_pkg::*;

   fe_item_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count above depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[Q_PTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

FILE: hdl/mrp_back.sv
module mrp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mrp_pkg::fe_item_type in_item,
   mrp_rsp_if.source            rsp_chan
);
   import mrp_pkg::*;

   logic                  en;
   logic [WORD_BITS:0]    v_ff;
   logic [REM_W-1:0]      rem_ff [WORD_BITS+1][3];
   logic [WORD_BITS-1:0]  low_ff [WORD_BITS+1][3];
   logic [WORD_BITS-1:0]  q_ff   [WORD_BITS+1][3];
   logic [DEN_W-1:0]      d_ff   [WORD_BITS+1];
   logic [2:0]            neg_ff [WORD_BITS+1];
   logic [2:0]            over_ff [WORD_BITS+1];
   logic                  zero_ff [WORD_BITS+1];

   logic [REM_W-1:0]      rem_in [WORD_BITS+1][3];
   logic [WORD_BITS:0]    qbit_in [3];

   logic                        rsp_valid_ff;
   logic signed [WORD_BITS-1:0] f_ff [3];
   logic signed [WORD_BITS-1:0] f_in [3];
   status_type                  status_ff, status_in;

   logic [WORD_BITS-1:0] qf;
   logic                 pos_sat, neg_sat, sat_any;

   assign en       = !rsp_valid_ff || rsp_chan.ready;
   assign in_ready = en;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.f_x    = f_ff[0];
   assign rsp_chan.f_y    = f_ff[1];
   assign rsp_chan.f_z    = f_ff[2];
   assign rsp_chan.status = status_ff;

   // one restoring step per stage: bring in the next dividend bit, try 2*|den|
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = '0;
         qbit_in[i]   = '0;
      end
      for (int k = 1; k <= WORD_BITS; k++) begin
         for (int i = 0; i < 3; i++) begin
            logic [REM_W-1:0] sh;
            sh = {rem_ff[k-1][i][REM_W-2:0], low_ff[k-1][i][WORD_BITS-1]};
            qbit_in[i][k] = (sh >= {1'b0, d_ff[k-1]});
            rem_in[k][i]  = qbit_in[i][k] ? (sh - {1'b0, d_ff[k-1]}) : sh;
         end
      end
   end

   // rounding already folded into the dividend; only saturation is left
   always_comb begin
      sat_any = 1'b0;
      qf      = '0;
      pos_sat = 1'b0;
      neg_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         qf      = q_ff[WORD_BITS][i];
         pos_sat = over_ff[WORD_BITS][i] || qf[WORD_BITS-1];
         neg_sat = over_ff[WORD_BITS][i] || (qf[WORD_BITS-1] && (qf[WORD_BITS-2:0] != '0));
         if (zero_ff[WORD_BITS]) begin
            f_in[i] = '0;
         end else if (neg_ff[WORD_BITS][i]) begin
            f_in[i] = neg_sat ? {1'b1, {(WORD_BITS-1){1'b0}}} : $signed(-qf);
            sat_any = sat_any || neg_sat;
         end else begin
            f_in[i] = pos_sat ? {1'b0, {(WORD_BITS-1){1'b1}}} : $signed(qf);
            sat_any = sat_any || pos_sat;
         end
      end
      if (zero_ff[WORD_BITS]) begin
         status_in = ST_ZERO_DEN;
      end else if (sat_any) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[WORD_BITS-1:0], in_valid};
         rsp_valid_ff <= v_ff[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i]  <= REM_W'(in_item.n[i] >> WORD_BITS);
            low_ff[0][i]  <= in_item.n[i][WORD_BITS-1:0];
            q_ff[0][i]    <= '0;
            over_ff[0][i] <= ((in_item.n[i] >> WORD_BITS) >= N_W'(in_item.d));
         end
         d_ff[0]    <= in_item.d;
         neg_ff[0]  <= in_item.neg;
         zero_ff[0] <= in_item.zero;

         for (int k = 1; k <= WORD_BITS; k++) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i] <= rem_in[k][i];
               low_ff[k][i] <= low_ff[k-1][i] << 1;
               q_ff[k][i]   <= {q_ff[k-1][i][WORD_BITS-2:0], qbit_in[i][k]};
            end
            d_ff[k]    <= d_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            over_ff[k] <= over_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end

         for (int i = 0; i < 3; i++) begin
            f_ff[i] <= f_in[i];
         end
         status_ff <= status_in;
      end
   end

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_ZERO_DEN) |->
         (f_ff[0] == '0 && f_ff[1] == '0 && f_ff[2] == '0))
      else $error("zero denominator with nonzero result");

   a_over_sat: assert property (@(posedge clock) disable iff (reset)
      (en && v_ff[WORD_BITS] && !zero_ff[WORD_BITS] && over_ff[WORD_BITS] != '0)
         |=> (status_ff == ST_SAT))
      else $error("quotient overflow not flagged");

endmodule

FILE: hdl/mrp_compose_top.sv
// MRP composition: f = ((1-|a|^2) b + (1-|b|^2) a - 2 b x a) / (1 + |a|^2|b|^2 - 2 a.b)
// req_chan carries one item: a_x..b_z, signed Q3.28. rsp_chan returns one item per
// request: f_x..f_z, signed Q3.28, rounded to nearest (ties away from zero) and
// saturated, plus status (ok / saturated / zero denominator, which outputs zeros).
// Both channels use valid/ready; an item moves when both are high.
// Throughput: one item per cycle sustained while rsp_chan.ready stays high.
// Path from request accept to response valid: 7 front stages forming the exact wide
// numerators and denominator, the 4-entry queue, then the divider: an entry stage,
// one restoring quotient bit per stage for WORD_BITS stages, and the output register.
// The front stalls only when its last stage holds an item and the queue is full;
// the back stalls as a whole while the response is held by rsp_chan.ready low, so
// up to 4 items plus the front's 7 stages keep flowing in during a stall.
// Reset (synchronous) empties all pipeline stages and the queue; no item state
// survives it and no response is produced for items in flight at reset.
module mrp_compose_top (
   input  logic      clock,
   input  logic      reset,
   mrp_req_if.sink   req_chan,
   mrp_rsp_if.source rsp_chan
);
   import mrp_pkg::*;

   // front -> queue
   logic        fe_valid, fe_ready;
   fe_item_type fe_item;
   // queue -> back
   logic        be_valid, be_ready;
   fe_item_type be_item;

   // products, sums, sign/magnitude split and dividend/divisor
   mrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_item  (fe_item)
   );

   // decouples arithmetic front from divider back
   mrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_item   (fe_item),
      .out_valid (be_valid),
      .out_ready (be_ready),
      .out_item  (be_item)
   );

   // pipelined divider, saturation, output register
   mrp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (be_valid),
      .in_ready (be_ready),
      .in_item  (be_item),
      .rsp_chan (rsp_chan)
   );

endmodule
